// ----- hw/rtl/demand_fetched_tile_map_macros.svh -----
// Assertion macros for the tile map checker.
// No dependencies; include by bare file name.
`ifndef DEMAND_FETCHED_TILE_MAP_MACROS_SVH
`define DEMAND_FETCHED_TILE_MAP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define DFTM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tile map check failed");

// Next-cycle implication, same clock and reset.
`define DFTM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tile map check failed");

`endif

// ----- hw/rtl/dftm_pkg.sv -----
// Shared constants, tag and function codes, and request/response structs
// for the demand-fetched tile map. No dependencies.
package dftm_pkg;

  localparam int unsigned PLANE_SIZE = 128;
  localparam int unsigned BLOCK_EDGE = 16;
  localparam int unsigned BLOCKS_PER_SIDE = PLANE_SIZE / BLOCK_EDGE;

  localparam int unsigned CRD_W      = 7;
  localparam int unsigned TYPE_W     = 7;
  localparam int unsigned BE_LOG2    = $clog2(BLOCK_EDGE);
  localparam int unsigned BLK_W      = $clog2(BLOCKS_PER_SIDE);

  localparam int unsigned TILE_W     = TYPE_W + 1;  // hidden flag on top
  localparam int unsigned TILE_DEPTH = PLANE_SIZE * PLANE_SIZE;
  localparam int unsigned TILE_AW    = $clog2(TILE_DEPTH);
  localparam int unsigned TAG_W      = 2;
  localparam int unsigned TAG_DEPTH  = BLOCKS_PER_SIDE * BLOCKS_PER_SIDE;
  localparam int unsigned TAG_AW     = $clog2(TAG_DEPTH);

  typedef enum logic [1:0] {
    TAG_ABSENT    = 2'd0,
    TAG_NEEDED    = 2'd1,
    TAG_REQUESTED = 2'd2,
    TAG_PRESENT   = 2'd3
  } tag_e;

  typedef enum logic [1:0] {
    FUNC_QUERY = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic {
    KIND_ANSWER = 1'b0,
    KIND_FETCH  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [CRD_W-1:0]  tile_x;
    logic [CRD_W-1:0]  tile_y;
    logic [TYPE_W-1:0] new_type;
    logic              new_hidden;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic              concealed;
    logic [TYPE_W-1:0] terrain_type;
    logic [BLK_W-1:0]  req_block_x;
    logic [BLK_W-1:0]  req_block_y;
    logic              last;
  } rsp_t;

  function automatic logic tile_in_plane(logic [CRD_W-1:0] x, logic [CRD_W-1:0] y);
    logic ok;
    ok = (int'(x) < PLANE_SIZE) && (int'(y) < PLANE_SIZE) &&
         ((int'(x) >> BE_LOG2) < BLOCKS_PER_SIDE) &&
         ((int'(y) >> BE_LOG2) < BLOCKS_PER_SIDE);
    return ok;
  endfunction

endpackage

// ----- hw/rtl/dftm_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Defaults from dftm_pkg.
module dftm_ram #(
  parameter int unsigned Width = dftm_pkg::TILE_W,
  parameter int unsigned Depth = dftm_pkg::TILE_DEPTH,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/demand_fetched_tile_map.sv -----
// Top level of the demand-fetched tile map: control sequencer, response register
// and the tile/tag RAMs. Depends on dftm_pkg and dftm_ram.
//
//   channel   direction  handshake                   payload
//   request   in         req_valid_i / req_ready_o   req_i  (dftm_pkg::req_t)
//   response  out        rsp_valid_o / rsp_ready_i   rsp_o  (dftm_pkg::rsp_t)
//
// Query: tag and tile RAM read, then answer and tag update.
// Write: both RAMs written at the accepting edge.
// Tick: the accepting cycle, one tag RAM read and one check per block, and a closing
//   state that sends the final request, if any; a stalled response register holds
//   the scan.
// After reset a clearing pass over the PLANE_SIZE^2 (16384) tile addresses zeroes
//   the tile RAM and the tag RAM; req_ready_o stays low until it ends.
// A waiting response does not block a new request; the register frees as it goes.
module demand_fetched_tile_map (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  dftm_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output dftm_pkg::rsp_t rsp_o
);

  localparam int unsigned TileAw = dftm_pkg::TILE_AW;
  localparam int unsigned TagAw  = dftm_pkg::TAG_AW;
  localparam int unsigned BlkW   = dftm_pkg::BLK_W;
  localparam int unsigned TileW  = dftm_pkg::TILE_W;
  localparam int unsigned TypeW  = dftm_pkg::TYPE_W;
  localparam int unsigned TagW   = dftm_pkg::TAG_W;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_QRESP    = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_SCAN_END = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [TileAw-1:0] clr_q, clr_d;
  logic [TagAw-1:0]  sc_q, sc_d;
  logic              pend_valid_q, pend_valid_d;
  logic [TagAw-1:0]  pend_idx_q, pend_idx_d;
  logic [TagAw-1:0]  q_bidx_q, q_bidx_d;
  logic              q_inpl_q, q_inpl_d;
  logic              rsp_valid_q, rsp_valid_d;
  dftm_pkg::rsp_t    rsp_q, rsp_d;

  // RAM ports
  logic              tile_we, tile_re;
  logic [TileAw-1:0] tile_waddr, tile_raddr;
  logic [TileW-1:0]  tile_wdata, tile_rdata;
  logic              tag_we, tag_re;
  logic [TagAw-1:0]  tag_waddr, tag_raddr;
  logic [TagW-1:0]   tag_wdata, tag_rdata;

  logic              acc, slot_free, in_pl, present, hit, go;
  logic [TagAw-1:0]  blk_idx;
  logic [TileAw-1:0] tile_idx;

  assign req_ready_o = (state_q == S_IDLE);
  assign acc         = req_valid_i && req_ready_o;
  assign slot_free   = !rsp_valid_q || rsp_ready_i;

  // power-of-two geometry: block index is {bx, by}, tile index is {x, y}
  assign in_pl    = dftm_pkg::tile_in_plane(req_i.tile_x, req_i.tile_y);
  assign blk_idx  = {req_i.tile_x[dftm_pkg::BE_LOG2 +: BlkW],
                     req_i.tile_y[dftm_pkg::BE_LOG2 +: BlkW]};
  assign tile_idx = {req_i.tile_x, req_i.tile_y};

  assign present = q_inpl_q && (tag_rdata == dftm_pkg::TAG_PRESENT);
  assign hit     = (tag_rdata == dftm_pkg::TAG_NEEDED);
  // a hit with a pending request must push that request out first
  assign go      = !(hit && pend_valid_q) || slot_free;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    sc_d         = sc_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    q_bidx_d     = q_bidx_q;
    q_inpl_d     = q_inpl_q;
    rsp_valid_d  = rsp_valid_q && !rsp_ready_i;
    rsp_d        = rsp_q;

    tile_we    = 1'b0;
    tile_waddr = tile_idx;
    tile_wdata = {req_i.new_hidden, req_i.new_type};
    tile_re    = 1'b0;
    tile_raddr = tile_idx;
    tag_we     = 1'b0;
    tag_waddr  = blk_idx;
    tag_wdata  = dftm_pkg::TAG_PRESENT;
    tag_re     = 1'b0;
    tag_raddr  = blk_idx;

    case (state_q)
      S_CLEAR: begin
        tile_we    = 1'b1;
        tile_waddr = clr_q;
        tile_wdata = '0;
        if (clr_q < TileAw'(dftm_pkg::TAG_DEPTH)) begin
          tag_we    = 1'b1;
          tag_waddr = clr_q[TagAw-1:0];
          tag_wdata = dftm_pkg::TAG_ABSENT;
        end
        clr_d = clr_q + TileAw'(1);
        if (clr_q == TileAw'(dftm_pkg::TILE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (acc) begin
          case (req_i.func)
            dftm_pkg::FUNC_QUERY: begin
              tag_re   = 1'b1;
              tile_re  = 1'b1;
              q_bidx_d = blk_idx;
              q_inpl_d = in_pl;
              state_d  = S_QRESP;
            end
            dftm_pkg::FUNC_WRITE: begin
              tile_we = in_pl;
              tag_we  = in_pl;
            end
            dftm_pkg::FUNC_TICK: begin
              sc_d         = '0;
              pend_valid_d = 1'b0;
              state_d      = S_SCAN_RD;
            end
            default: ;
          endcase
        end
      end

      S_QRESP: begin
        if (slot_free) begin
          rsp_valid_d        = 1'b1;
          rsp_d.kind         = dftm_pkg::KIND_ANSWER;
          rsp_d.concealed    = present ? tile_rdata[TileW-1] : 1'b1;
          rsp_d.terrain_type = present ? tile_rdata[TypeW-1:0] : '0;
          rsp_d.req_block_x  = '0;
          rsp_d.req_block_y  = '0;
          rsp_d.last         = 1'b1;
          // first touch of an absent block asks for it
          if (q_inpl_q && (tag_rdata == dftm_pkg::TAG_ABSENT)) begin
            tag_we    = 1'b1;
            tag_waddr = q_bidx_q;
            tag_wdata = dftm_pkg::TAG_NEEDED;
          end
          state_d = S_IDLE;
        end
      end

      S_SCAN_RD: begin
        tag_re    = 1'b1;
        tag_raddr = sc_q;
        state_d   = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        // tag data holds while stalled here (no new read)
        if (go) begin
          if (hit) begin
            tag_we       = 1'b1;
            tag_waddr    = sc_q;
            tag_wdata    = dftm_pkg::TAG_REQUESTED;
            pend_valid_d = 1'b1;
            pend_idx_d   = sc_q;
            if (pend_valid_q) begin
              rsp_valid_d        = 1'b1;
              rsp_d.kind         = dftm_pkg::KIND_FETCH;
              rsp_d.concealed    = 1'b0;
              rsp_d.terrain_type = '0;
              rsp_d.req_block_x  = pend_idx_q[TagAw-1 -: BlkW];
              rsp_d.req_block_y  = pend_idx_q[BlkW-1:0];
              rsp_d.last         = 1'b0;
            end
          end
          sc_d    = sc_q + TagAw'(1);
          state_d = (sc_q == TagAw'(dftm_pkg::TAG_DEPTH - 1)) ? S_SCAN_END : S_SCAN_RD;
        end
      end

      S_SCAN_END: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          rsp_valid_d        = 1'b1;
          rsp_d.kind         = dftm_pkg::KIND_FETCH;
          rsp_d.concealed    = 1'b0;
          rsp_d.terrain_type = '0;
          rsp_d.req_block_x  = pend_idx_q[TagAw-1 -: BlkW];
          rsp_d.req_block_y  = pend_idx_q[BlkW-1:0];
          rsp_d.last         = 1'b1;
          pend_valid_d       = 1'b0;
          state_d            = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      sc_q         <= '0;
      pend_valid_q <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      sc_q         <= sc_d;
      pend_valid_q <= pend_valid_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    q_bidx_q   <= q_bidx_d;
    q_inpl_q   <= q_inpl_d;
    rsp_q      <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  dftm_ram #(
    .Width (TileW),
    .Depth (dftm_pkg::TILE_DEPTH)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (tile_waddr),
    .wdata_i (tile_wdata),
    .re_i    (tile_re),
    .raddr_i (tile_raddr),
    .rdata_o (tile_rdata)
  );

  dftm_ram #(
    .Width (TagW),
    .Depth (dftm_pkg::TAG_DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

endmodule

// ----- hw/rtl/dftm_checker.sv -----
// Port-level checker for the tile map, bound to the top level.
// Depends on dftm_pkg and demand_fetched_tile_map_macros.svh.
`include "demand_fetched_tile_map_macros.svh"

module dftm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input dftm_pkg::req_t req_i,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input dftm_pkg::rsp_t rsp_o
);

  // stalled response holds
  `DFTM_ASSERT_NEXT(a_rsp_hold, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_o))

  // queries and ticks take the sequencer away from idle once accepted
  `DFTM_ASSERT_NEXT(a_busy_after, req_valid_i && req_ready_o && (req_i.func == dftm_pkg::FUNC_QUERY || req_i.func == dftm_pkg::FUNC_TICK), !req_ready_o)

  // a fresh answer comes out of the answer cycle, never straight from idle
  `DFTM_ASSERT_IMPL(a_answer_src, $rose(rsp_valid_o) && rsp_o.kind == dftm_pkg::KIND_ANSWER, !$past(req_ready_o))

  // answers always close their request
  `DFTM_ASSERT_IMPL(a_answer_last, rsp_valid_o && rsp_o.kind == dftm_pkg::KIND_ANSWER, rsp_o.last && rsp_o.req_block_x == '0 && rsp_o.req_block_y == '0)

endmodule

bind demand_fetched_tile_map dftm_checker u_dftm_checker (.*);

// ----- verif/tb_demand_fetched_tile_map.sv -----
// Self-checking testbench for demand_fetched_tile_map: queries, tile writes and
// block scans go in, and answers and fetch requests are compared with a shadow map.
// Depends on dftm_pkg and the demand_fetched_tile_map RTL.
module tb_demand_fetched_tile_map;

  localparam int unsigned CrdW  = dftm_pkg::CRD_W;
  localparam int unsigned TypeW = dftm_pkg::TYPE_W;
  localparam int unsigned BlkW  = dftm_pkg::BLK_W;
  localparam int unsigned Side  = dftm_pkg::BLOCKS_PER_SIDE;

  // Function code 3 has no meaning; the map must drop it silently.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // No handshake for this many cycles means the map is stuck. The clearing
  // pass after reset alone writes all PLANE_SIZE^2 tile addresses, so leave ample room.
  localparam int unsigned STALL_LIMIT  = 4 * dftm_pkg::TILE_DEPTH;
  // Long receiver hold-off, to back the map up into its request port.
  localparam int unsigned HOLD_CYCLES  = 300;
  // Settling time at the end: one full scan of the tags plus margin.
  localparam int unsigned DRAIN_CYCLES = 2 * dftm_pkg::TAG_DEPTH + 40;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           req_valid_i = 1'b0;
  logic           req_ready_o;
  dftm_pkg::req_t req_i       = '0;
  logic           rsp_valid_o;
  logic           rsp_ready_i = 1'b0;
  dftm_pkg::rsp_t rsp_o;

  // Shadow copy of the map state: block tags and the tile store.
  dftm_pkg::tag_e              shadow_tag  [dftm_pkg::TAG_DEPTH];
  logic [dftm_pkg::TILE_W-1:0] shadow_tile [dftm_pkg::TILE_DEPTH];

  // Responses the map still owes, oldest first.
  dftm_pkg::rsp_t    due_rsp_q [$];
  // Tiles written lately ({x, y}) and blocks sent out for fetch ({bx, by});
  // random traffic aims at these so queries hit present tiles and writes
  // complete the fetch flow the way a real loader would.
  logic [2*CrdW-1:0] written_q [$];
  logic [2*BlkW-1:0] fetched_blk_q [$];

  int unsigned err_cnt      = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on      = 1'b0;
  bit          hold_req     = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  demand_fetched_tile_map i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow map
  // ---------------------------------------------------------------------------

  // With a 7-bit coordinate and a 128-tile plane every tile lies on the plane,
  // but keep the bound check so the shadow follows other plane sizes.
  function automatic bit coord_on_plane(logic [CrdW-1:0] x, logic [CrdW-1:0] y);
    return (x < dftm_pkg::PLANE_SIZE) && (y < dftm_pkg::PLANE_SIZE) &&
           ((x / dftm_pkg::BLOCK_EDGE) < Side) && ((y / dftm_pkg::BLOCK_EDGE) < Side);
  endfunction

  // Apply one accepted request to the shadow map and queue what it owes.
  task automatic tile_map_step(input dftm_pkg::req_t r);
    int unsigned    blk;
    int unsigned    til;
    int unsigned    first;
    dftm_pkg::rsp_t a;
    blk = (r.tile_x / dftm_pkg::BLOCK_EDGE) * Side + (r.tile_y / dftm_pkg::BLOCK_EDGE);
    til = r.tile_x * dftm_pkg::PLANE_SIZE + r.tile_y;
    a   = '0;
    case (r.func)
      dftm_pkg::FUNC_QUERY: begin
        a.kind      = dftm_pkg::KIND_ANSWER;
        a.concealed = 1'b1;
        a.last      = 1'b1;
        if (coord_on_plane(r.tile_x, r.tile_y)) begin
          if (shadow_tag[blk] == dftm_pkg::TAG_ABSENT) shadow_tag[blk] = dftm_pkg::TAG_NEEDED;
          // Only a present block reveals its tile; otherwise hidden, type 0.
          if (shadow_tag[blk] == dftm_pkg::TAG_PRESENT) begin
            a.concealed    = shadow_tile[til][dftm_pkg::TILE_W-1];
            a.terrain_type = shadow_tile[til][TypeW-1:0];
          end
        end
        due_rsp_q.push_back(a);
      end
      dftm_pkg::FUNC_WRITE: begin
        // Marks the block present whatever its tag was, requested included.
        if (coord_on_plane(r.tile_x, r.tile_y)) begin
          shadow_tile[til] = {r.new_hidden, r.new_type};
          shadow_tag[blk]  = dftm_pkg::TAG_PRESENT;
        end
      end
      dftm_pkg::FUNC_TICK: begin
        // Block column outer, block row inner; last marks the final request.
        first = due_rsp_q.size();
        for (int bx = 0; bx < Side; bx++) begin
          for (int by = 0; by < Side; by++) begin
            if (shadow_tag[bx * Side + by] == dftm_pkg::TAG_NEEDED) begin
              a             = '0;
              a.kind        = dftm_pkg::KIND_FETCH;
              a.req_block_x = BlkW'(bx);
              a.req_block_y = BlkW'(by);
              due_rsp_q.push_back(a);
              fetched_blk_q.push_back({BlkW'(bx), BlkW'(by)});
              shadow_tag[bx * Side + by] = dftm_pkg::TAG_REQUESTED;
            end
          end
        end
        if (due_rsp_q.size() > first) begin
          a      = due_rsp_q.pop_back();
          a.last = 1'b1;
          due_rsp_q.push_back(a);
        end
      end
      default: ;  // unused code: no state change, no response
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic dftm_pkg::req_t mk_req(logic [1:0] f, int x = 0, int y = 0,
                                            int t = 0, bit h = 1'b0);
    dftm_pkg::req_t r;
    r.func       = f;
    r.tile_x     = CrdW'(x);
    r.tile_y     = CrdW'(y);
    r.new_type   = TypeW'(t);
    r.new_hidden = h;
    return r;
  endfunction

  // Offer one request. Valid stays high after acceptance; the next call either
  // swaps the payload or drops valid for an idle burst at the following
  // falling edge, so valid is never lowered and raised in one step.
  task automatic send_req(input dftm_pkg::req_t r);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    tile_map_step(r);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: ready with random stall bursts, plus the long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        rsp_ready_i <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready_i <= 1'b1;
      end
    end
  end

  // Compare every accepted response with the oldest one owed.
  always @(posedge clk_i) begin
    dftm_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (due_rsp_q.size() == 0) begin
        $error("unexpected response %p", rsp_o);
        err_cnt++;
      end else begin
        want = due_rsp_q.pop_front();
        if (rsp_o.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, rsp_o.kind);
          err_cnt++;
        end
        if (rsp_o.concealed !== want.concealed) begin
          $error("concealed: expected %0d, got %0d", want.concealed, rsp_o.concealed);
          err_cnt++;
        end
        if (rsp_o.terrain_type !== want.terrain_type) begin
          $error("terrain_type: expected %0d, got %0d",
                 want.terrain_type, rsp_o.terrain_type);
          err_cnt++;
        end
        if (rsp_o.req_block_x !== want.req_block_x) begin
          $error("req_block_x: expected %0d, got %0d",
                 want.req_block_x, rsp_o.req_block_x);
          err_cnt++;
        end
        if (rsp_o.req_block_y !== want.req_block_y) begin
          $error("req_block_y: expected %0d, got %0d",
                 want.req_block_y, rsp_o.req_block_y);
          err_cnt++;
        end
        if (rsp_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp_o.last);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk the tag life cycle on a few corner blocks.
  task automatic test_directed();
    send_req(mk_req(dftm_pkg::FUNC_TICK));                       // nothing needed yet
    send_req(mk_req(dftm_pkg::FUNC_WRITE, 127, 0, 85, 1'b1));    // write into absent block
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 127, 0));              // present, hidden tile
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 0, 0));                // absent -> needed
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 127, 127));            // far corner -> needed
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 15, 15));              // same block, stays needed
    send_req(mk_req(FUNC_UNUSED, 127, 127, 127, 1'b1));          // dropped
    send_req(mk_req(dftm_pkg::FUNC_TICK));                       // two fetch requests
    send_req(mk_req(dftm_pkg::FUNC_TICK));                       // all requested: none
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 0, 15));               // requested stays requested
    send_req(mk_req(dftm_pkg::FUNC_WRITE, 0, 0, 127, 1'b0));     // requested -> present
    send_req(mk_req(dftm_pkg::FUNC_WRITE, 15, 15, 0, 1'b1));
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 0, 0));                // visible, type 127
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 15, 15));              // hidden, type 0
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 1, 0));                // never written: zeros
    send_req(mk_req(dftm_pkg::FUNC_WRITE, 0, 0, 42, 1'b1));      // overwrite
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 0, 0));
    send_req(mk_req(dftm_pkg::FUNC_WRITE, 112, 112, 1, 1'b0));   // far block -> present
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 127, 127));
    send_req(mk_req(dftm_pkg::FUNC_QUERY, 112, 112));
    send_req(mk_req(dftm_pkg::FUNC_TICK));
  endtask

  // Mostly the fetch flow (query, scan, write back into fetched blocks), with
  // some stray writes and dropped codes mixed in. All fields start random.
  task automatic test_random(input int unsigned n);
    dftm_pkg::req_t    r;
    int unsigned       pick;
    logic [2*CrdW-1:0] xy;
    logic [2*BlkW-1:0] bxy;
    for (int unsigned i = 0; i < n; i++) begin
      r    = dftm_pkg::req_t'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        r.func = dftm_pkg::FUNC_QUERY;
        if (written_q.size() > 0 && $urandom_range(0, 1) == 1) begin
          xy       = written_q[$urandom_range(0, written_q.size() - 1)];
          r.tile_x = xy[2*CrdW-1:CrdW];
          r.tile_y = xy[CrdW-1:0];
        end
      end else if (pick < 75) begin
        r.func = dftm_pkg::FUNC_WRITE;
        if (fetched_blk_q.size() > 0 && $urandom_range(0, 2) != 0) begin
          bxy      = fetched_blk_q[$urandom_range(0, fetched_blk_q.size() - 1)];
          r.tile_x = CrdW'(bxy[2*BlkW-1:BlkW] * dftm_pkg::BLOCK_EDGE +
                           $urandom_range(0, dftm_pkg::BLOCK_EDGE - 1));
          r.tile_y = CrdW'(bxy[BlkW-1:0] * dftm_pkg::BLOCK_EDGE +
                           $urandom_range(0, dftm_pkg::BLOCK_EDGE - 1));
        end
        written_q.push_back({r.tile_x, r.tile_y});
        if (written_q.size() > 32) void'(written_q.pop_front());
      end else if (pick < 93) begin
        r.func = dftm_pkg::FUNC_TICK;
      end else begin
        r.func = FUNC_UNUSED;
      end
      send_req(r);
    end
  endtask

  // Receiver goes deaf for a long stretch while queries and a scan keep
  // coming; the response register fills and the request port must stall.
  task automatic test_pressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_req(mk_req(dftm_pkg::FUNC_QUERY, $urandom_range(0, 127), $urandom_range(0, 127)));
    end
    send_req(mk_req(dftm_pkg::FUNC_TICK));
    for (int i = 0; i < 3; i++) begin
      send_req(mk_req(dftm_pkg::FUNC_QUERY, $urandom_range(0, 127), $urandom_range(0, 127)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (shadow_tag[i]) shadow_tag[i] = dftm_pkg::TAG_ABSENT;
    foreach (shadow_tile[i]) shadow_tile[i] = '0;

    // Reset is held at the start; the map then runs its clearing pass on its own
    // and holds req_ready_o low until done, which send_req simply waits out.
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_on = 1'b1;
    test_directed();
    test_random(200);
    test_pressure();
    idle_on = 1'b0;  // closing stretch at full rate on both sides
    test_random(25);

    @(negedge clk_i);
    req_valid_i <= 1'b0;

    while (due_rsp_q.size() != 0) @(posedge clk_i);
    // Catch any stray response after the last one owed.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
